[rtl/core/tei_pkg.sv]
// Shared types and constants for the trapezoid energy integrator.
package tei_pkg;

  localparam int unsigned POWER_BITS_DEFAULT = 24;
  localparam int unsigned TIME_BITS          = 32;
  localparam int unsigned ENERGY_BITS        = 64;

  localparam logic [TIME_BITS-1:0] INTERVAL_RESET = 32'd1000;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  typedef enum logic [1:0] {
    ST_NOT_READY = 2'd0,
    ST_VALID     = 2'd1,
    ST_ESTIMATED = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef struct packed {
    logic    req_type;
    status_t sensor_status;
    logic    power_present;
  } sample_ctl_t;

  typedef struct packed {
    status_t result_status;
    logic    power_valid;
  } result_ctl_t;

endpackage

[rtl/core/tei_input_reg.sv]
// Input register stage that holds one accepted sample transaction.
module tei_input_reg
  import tei_pkg::*;
#(
  parameter int unsigned POWER_BITS = POWER_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_ctl_t           ctl_in,
  input  logic [TIME_BITS-1:0]  now_in,
  input  logic [POWER_BITS-1:0] power_in,
  input  logic                  advance,
  output logic                  held_valid,
  output sample_ctl_t           held_ctl,
  output logic [TIME_BITS-1:0]  held_now,
  output logic [POWER_BITS-1:0] held_power
);

  logic accept;

  assign sample_stall = held_valid && !advance;
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_ctl   <= ctl_in;
      held_now   <= now_in;
      held_power <= power_in;
    end
  end

endmodule

[rtl/core/tei_integrator.sv]
// Evaluation state, reading classification and trapezoidal energy update.
module tei_integrator
  import tei_pkg::*;
#(
  parameter int unsigned POWER_BITS = POWER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [TIME_BITS-1:0]   cfg_data,
  input  logic                   fire,
  input  sample_ctl_t            ctl,
  input  logic [TIME_BITS-1:0]   now_ms,
  input  logic [POWER_BITS-1:0]  power_mw,
  output logic                   emit,
  output result_ctl_t            res_ctl,
  output logic [POWER_BITS-2:0]  res_power,
  output logic [ENERGY_BITS-1:0] res_energy
);

  localparam int unsigned PROD_BITS = POWER_BITS + TIME_BITS;

  logic [TIME_BITS-1:0]   interval;
  logic                   evaluated_once;
  logic                   evaluated_once_next;
  logic [TIME_BITS-1:0]   last_eval_time;
  logic [TIME_BITS-1:0]   last_eval_time_next;
  logic                   baseline_valid;
  logic                   baseline_valid_next;
  logic [TIME_BITS-1:0]   baseline_time;
  logic [TIME_BITS-1:0]   baseline_time_next;
  logic [POWER_BITS-2:0]  previous_power;
  logic [POWER_BITS-2:0]  previous_power_next;
  logic [ENERGY_BITS-1:0] energy_accumulator;
  logic [ENERGY_BITS-1:0] energy_accumulator_next;

  logic [TIME_BITS-1:0]   since_eval;
  logic                   too_early;
  logic                   requires_value;
  logic                   negative;
  logic                   bad_reading;
  logic [POWER_BITS-2:0]  raw;
  logic [POWER_BITS-1:0]  power_sum;
  logic [TIME_BITS-1:0]   elapsed;
  logic [PROD_BITS-1:0]   product;
  logic [ENERGY_BITS:0]   candidate;
  logic                   overflow;

  assign raw            = power_mw[POWER_BITS-2:0];
  assign negative       = power_mw[POWER_BITS-1];
  assign since_eval     = now_ms - last_eval_time;
  assign too_early      = evaluated_once && (since_eval < interval);
  assign requires_value = (ctl.sensor_status == ST_VALID) ||
                          (ctl.sensor_status == ST_ESTIMATED);
  assign bad_reading    = (requires_value && (!ctl.power_present || negative)) ||
                          (!requires_value && ctl.power_present);
  assign power_sum      = {1'b0, previous_power} + {1'b0, raw};
  assign elapsed        = now_ms - baseline_time;
  assign product        = PROD_BITS'(power_sum) * PROD_BITS'(elapsed);
  assign candidate      = {1'b0, energy_accumulator} + {1'b0, ENERGY_BITS'(product)};
  assign overflow       = baseline_valid && candidate[ENERGY_BITS];

  always_comb begin
    evaluated_once_next     = evaluated_once;
    last_eval_time_next     = last_eval_time;
    baseline_valid_next     = baseline_valid;
    baseline_time_next      = baseline_time;
    previous_power_next     = previous_power;
    energy_accumulator_next = energy_accumulator;
    emit                    = 1'b0;
    res_ctl.result_status   = ctl.sensor_status;
    res_ctl.power_valid     = 1'b0;
    res_power               = '0;
    if (fire) begin
      priority if (ctl.req_type == REQ_CLEAR) begin
        energy_accumulator_next = '0;
        baseline_valid_next     = 1'b0;
        baseline_time_next      = '0;
        previous_power_next     = '0;
      end else if (too_early) begin
        emit = 1'b0;
      end else begin
        emit                = 1'b1;
        evaluated_once_next = 1'b1;
        last_eval_time_next = now_ms;
        priority if (bad_reading || (requires_value && overflow)) begin
          res_ctl.result_status = ST_INVALID;
          baseline_valid_next   = 1'b0;
          baseline_time_next    = '0;
          previous_power_next   = '0;
        end else if (!requires_value) begin
          baseline_valid_next = 1'b0;
          baseline_time_next  = '0;
          previous_power_next = '0;
        end else begin
          if (baseline_valid) begin
            energy_accumulator_next = candidate[ENERGY_BITS-1:0];
          end
          previous_power_next = raw;
          baseline_time_next  = now_ms;
          baseline_valid_next = 1'b1;
          res_ctl.power_valid = 1'b1;
          res_power           = raw;
        end
      end
    end
    res_energy = energy_accumulator_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval           <= INTERVAL_RESET;
      evaluated_once     <= 1'b0;
      last_eval_time     <= '0;
      baseline_valid     <= 1'b0;
      baseline_time      <= '0;
      previous_power     <= '0;
      energy_accumulator <= '0;
    end else begin
      if (cfg_write) begin
        interval <= cfg_data;
      end
      evaluated_once     <= evaluated_once_next;
      last_eval_time     <= last_eval_time_next;
      baseline_valid     <= baseline_valid_next;
      baseline_time      <= baseline_time_next;
      previous_power     <= previous_power_next;
      energy_accumulator <= energy_accumulator_next;
    end
  end

endmodule

[rtl/core/tei_output_reg.sv]
// Result register that holds one result transaction until the receiver takes it.
module tei_output_reg
  import tei_pkg::*;
#(
  parameter int unsigned POWER_BITS = POWER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  result_ctl_t            ctl_in,
  input  logic [POWER_BITS-2:0]  power_in,
  input  logic [ENERGY_BITS-1:0] energy_in,
  output logic                   ready,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_ctl_t            ctl_out,
  output logic [POWER_BITS-2:0]  power_out,
  output logic [ENERGY_BITS-1:0] energy_out
);

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_out    <= ctl_in;
      power_out  <= power_in;
      energy_out <= energy_in;
    end
  end

endmodule

[rtl/core/trapezoid_energy_integrator_unit.sv]
// Top level of the trapezoid energy integrator.
//
// Sample channel: sample_valid / sample_stall with req_type, now_ms, sensor_status,
// power_present and power_mw. A transaction moves when valid is high and stall low.
// Result channel: result_valid / result_stall with result_status, power_valid,
// power_out_mw and energy_half_uj; at most one result per sample transaction.
// cfg_write loads cfg_data into the reading interval register (ms).
// A sample lands in the input register, is evaluated there by one multiply and one
// 64-bit add once the result register is ready, which then registers the result.
// Throughput is one transaction per cycle while the receiver does not stall; ticks
// that come too early and clear requests use their slot but produce no result.
// rst clears the energy, the baseline and the evaluation timer and sets the
// interval to 1000 ms. While the receiver stalls, the result register holds,
// the input register holds its transaction, and sample_stall rises once it is full.
module trapezoid_energy_integrator_unit
  import tei_pkg::*;
#(
  parameter int unsigned POWER_BITS = POWER_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [TIME_BITS-1:0]   cfg_data,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  logic                   req_type,
  input  logic [TIME_BITS-1:0]   now_ms,
  input  logic [1:0]             sensor_status,
  input  logic                   power_present,
  input  logic [POWER_BITS-1:0]  power_mw,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [1:0]             result_status,
  output logic                   power_valid,
  output logic [POWER_BITS-2:0]  power_out_mw,
  output logic [ENERGY_BITS-1:0] energy_half_uj
);

  sample_ctl_t            ctl_in;
  sample_ctl_t            held_ctl;
  logic                   held_valid;
  logic [TIME_BITS-1:0]   held_now;
  logic [POWER_BITS-1:0]  held_power;
  logic                   out_ready;
  logic                   advance;
  logic                   emit;
  result_ctl_t            res_ctl;
  result_ctl_t            out_ctl;
  logic [POWER_BITS-2:0]  res_power;
  logic [ENERGY_BITS-1:0] res_energy;

  assign ctl_in.req_type      = req_type;
  assign ctl_in.sensor_status = status_t'(sensor_status);
  assign ctl_in.power_present = power_present;

  assign advance = held_valid && out_ready;

  tei_input_reg #(
    .POWER_BITS(POWER_BITS)
  ) u_input_reg (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .ctl_in       (ctl_in),
    .now_in       (now_ms),
    .power_in     (power_mw),
    .advance      (advance),
    .held_valid   (held_valid),
    .held_ctl     (held_ctl),
    .held_now     (held_now),
    .held_power   (held_power)
  );

  tei_integrator #(
    .POWER_BITS(POWER_BITS)
  ) u_integrator (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .fire       (advance),
    .ctl        (held_ctl),
    .now_ms     (held_now),
    .power_mw   (held_power),
    .emit       (emit),
    .res_ctl    (res_ctl),
    .res_power  (res_power),
    .res_energy (res_energy)
  );

  tei_output_reg #(
    .POWER_BITS(POWER_BITS)
  ) u_output_reg (
    .clk          (clk),
    .rst          (rst),
    .load         (emit),
    .ctl_in       (res_ctl),
    .power_in     (res_power),
    .energy_in    (res_energy),
    .ready        (out_ready),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctl_out      (out_ctl),
    .power_out    (power_out_mw),
    .energy_out   (energy_half_uj)
  );

  assign result_status = out_ctl.result_status;
  assign power_valid   = out_ctl.power_valid;

endmodule
